[hdl/dual_thermocouple_ema_kalman_core_macros.svh]
// Assertion macros used by the core RTL file.
`ifndef DUAL_THERMOCOUPLE_EMA_KALMAN_CORE_MACROS_SVH
`define DUAL_THERMOCOUPLE_EMA_KALMAN_CORE_MACROS_SVH

// Property that holds on every clock edge outside reset.
`define DTK_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication that holds from one clock edge to the next.
`define DTK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/dtk_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package dtk_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int TEMP_W = 28;
	localparam logic [15:0] EMA_WEIGHT_RST = 16'd66;
	localparam logic [31:0] PROC_NOISE_RST = 32'd2560;
	localparam logic [31:0] MEAS_NOISE_RST = 32'd51200000;
	localparam logic [31:0] VAR_RST = 32'd3;
	localparam logic [1:0] REG_EMA_WEIGHT = 2'd0;
	localparam logic [1:0] REG_PROC_NOISE = 2'd1;
	localparam logic [1:0] REG_MEAS_NOISE = 2'd2;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX = 28'sh7FFFFFF;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN = -28'sh8000000;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

	function automatic logic signed [TEMP_W-1:0] sat_temp(input logic signed [63:0] v);
		if (v > 64'(TEMP_MAX)) return TEMP_MAX;
		if (v < 64'(TEMP_MIN)) return TEMP_MIN;
		return v[TEMP_W-1:0];
	endfunction
endpackage
`default_nettype wire

[hdl/dual_thermocouple_ema_kalman_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel | Direction | Handshake         | Payload
// in      | input     | in_valid/in_stall | frame_a, frame_b
// out     | output    | out_valid/out_stall | selected_temp, probe_error,
//         |           |                   | averaged_temp, filtered_temp
// cfg     | input     | cfg_we            | cfg_index, cfg_data
// Each item passes through the states EMA, DIV (the divider works out the gain), UPD and
// OUT, and the next item is accepted back in IDLE, so a new item is not taken before the
// last one is through. The result register is loaded on leaving OUT.
// The input is stalled from acceptance until the result register is loaded.
// Reset is asynchronous and active low and restores config registers, control and filter state.
// A result that waits under stall also stalls the input.
module dual_thermocouple_ema_kalman_core #(
	parameter int FRAC_BITS = dtk_pkg::FRAC_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [15:0] frame_a,
	input  wire logic [15:0] frame_b,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic signed [13:0] selected_temp,
	output logic             probe_error,
	output logic signed [dtk_pkg::TEMP_W-1:0] averaged_temp,
	output logic signed [dtk_pkg::TEMP_W-1:0] filtered_temp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import dtk_pkg::*;
	`include "dual_thermocouple_ema_kalman_core_macros.svh"

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EMA  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_UPD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]  state_q;
	logic [15:0] w_q;
	logic [31:0] qn_q, rn_q;
	logic signed [TEMP_W-1:0] ema_q, est_q;
	logic [31:0] var_q, pp_q;
	logic signed [13:0] sel_q;
	logic        err_q;
	logic [24:0] k_q;
	logic        out_valid_q;
	logic        div_done;
	logic [24:0] div_quot;
	div_ctl_t    div_ctl;

	// Frame decode and probe choice.
	logic open_a, open_b;
	logic signed [13:0] sel_c;
	assign open_a = frame_a[2];
	assign open_b = frame_b[2];
	always_comb begin
		if (!open_a) sel_c = $signed({1'b0, frame_a[15:3]});
		else if (!open_b) sel_c = $signed({1'b0, frame_b[15:3]});
		else sel_c = -14'sd4;
	end

	wire accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE) || (out_valid_q && out_stall);

	// The EMA multiply: one signed 29 by 17 product, rounded half up.
	logic signed [63:0] x_c, d_c, pe_c, ema_n;
	assign x_c = 64'(sel_q) <<< (FRAC_BITS - 2);
	assign d_c = x_c - 64'(ema_q);
	assign pe_c = d_c * $signed({1'b0, w_q});
	assign ema_n = 64'(ema_q) + ((pe_c + 64'sd32768) >>> 16);

	// Prediction with saturation to 32 bits.
	logic [32:0] pp_sum;
	assign pp_sum = {1'b0, var_q} + {1'b0, qn_q};

	// Update of estimate and variance with the finished gain.
	logic signed [63:0] e_c, pk_c, est_n;
	logic [24:0] k_c;
	logic [57:0] pv_c;
	assign k_c = (div_quot > 25'h1000000) ? 25'h1000000 : div_quot;
	assign e_c = 64'(ema_q) - 64'(est_q);
	assign pk_c = e_c * $signed({39'd0, k_q});
	assign est_n = 64'(est_q) + ((pk_c + 64'sd8388608) >>> 24);
	assign pv_c = 58'(25'h1000000 - k_q) * 58'(pp_q) + 58'h800000;

	assign div_ctl.start = (state_q == ST_EMA);
	assign div_ctl.busy  = (state_q == ST_DIV);

	dtk_div u_div (
		.clk(clk), .arst_n(arst_n), .ctl_in(div_ctl),
		.num(pp_q), .den({1'b0, pp_q} + {1'b0, rn_q}),
		.done(div_done), .quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			w_q <= EMA_WEIGHT_RST;
			qn_q <= PROC_NOISE_RST;
			rn_q <= MEAS_NOISE_RST;
			ema_q <= TEMP_W'(25 <<< FRAC_BITS);
			est_q <= TEMP_W'(25 <<< FRAC_BITS);
			var_q <= VAR_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_EMA_WEIGHT: w_q <= cfg_data[15:0];
					REG_PROC_NOISE: qn_q <= cfg_data;
					REG_MEAS_NOISE: rn_q <= cfg_data;
					default: ;
				endcase
			end
			// A new result is loaded once the old one has gone or was never there.
			if (state_q == ST_OUT && !(out_valid_q && out_stall)) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (accept) state_q <= ST_EMA;
				ST_EMA: begin
					ema_q <= sat_temp(ema_n);
					state_q <= ST_DIV;
				end
				ST_DIV: if (div_done) state_q <= ST_UPD;
				ST_UPD: begin
					// A zero denominator leaves the gain at zero.
					est_q <= sat_temp(est_n);
					var_q <= pv_c[55:24];
					state_q <= ST_OUT;
				end
				ST_OUT: if (!(out_valid_q && out_stall)) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q <= sel_c;
			err_q <= open_a && open_b;
		end
		if (state_q == ST_IDLE) pp_q <= pp_sum[32] ? 32'hFFFFFFFF : pp_sum[31:0];
		if (div_done) k_q <= ({1'b0, pp_q} + {1'b0, rn_q} == 33'd0) ? 25'd0 : k_c;
		if (state_q == ST_OUT && !(out_valid_q && out_stall)) begin
			selected_temp <= sel_q;
			probe_error <= err_q;
			averaged_temp <= ema_q;
			filtered_temp <= est_q;
		end
	end

	assign out_valid = out_valid_q;

	`DTK_ASSERT(a_busy_stalls, (state_q != ST_IDLE) |-> in_stall, "input not stalled while busy")
	`DTK_ASSERT_NEXT(a_accept_starts, accept, state_q == ST_EMA, "accept did not start sequence")
	`DTK_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid, "result dropped under stall")
endmodule
`default_nettype wire

[hdl/dtk_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Restoring divider for the gain: q = floor(num * 2^24 / den), one bit a cycle.
module dtk_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dtk_pkg::div_ctl_t ctl_in,
	input  wire logic [31:0] num,
	input  wire logic [32:0] den,
	output logic             done,
	output logic [24:0]      quot
);
	import dtk_pkg::*;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic        done_q;
	logic [33:0] rem_q;
	logic [56:0] dvd_q;
	logic [24:0] quot_q;
	logic [33:0] trial;

	// Numerator bits shift in from the top, so only the last 25 quotient bits are kept.
	assign trial = {rem_q[32:0], dvd_q[56]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl_in.start) begin
			run_q <= 1'b1;
			cnt_q <= 6'd57;
		end else if (run_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) run_q <= 1'b0;
		end
	end

	// Done is registered and rises at the edge that shifts in the last quotient bit, unless a start arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && cnt_q == 6'd1 && !ctl_in.start;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			rem_q <= '0;
			dvd_q <= {1'b0, num, 24'd0};
			quot_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[55:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial;
				quot_q <= {quot_q[23:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], dvd_q[56]};
				quot_q <= {quot_q[23:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire
